### src/double_buffer_dac_player_assert.svh
// ----------------------------------------------------------------------------
// Double buffer DAC player: assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_BUFFER_DAC_PLAYER_ASSERT_SVH
`define DOUBLE_BUFFER_DAC_PLAYER_ASSERT_SVH

`ifndef SYNTHESIS
`define DBDP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DBDP_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define DBDP_ASSERT(lbl, clk, rstn, prop, msg)
`define DBDP_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### src/dbdp_pkg.sv
// ----------------------------------------------------------------------------
// dbdp_pkg
// Shared constants and types of the double buffer DAC player.
// ----------------------------------------------------------------------------
`default_nettype none

package dbdp_pkg;

  localparam int unsigned BUFFER_BYTES_DEFAULT = 512;
  localparam int unsigned QUEUE_DEPTH          = 2;

  localparam logic [1:0] ACT_WRITE     = 2'd0;
  localparam logic [1:0] ACT_FILL_DONE = 2'd1;
  localparam logic [1:0] ACT_TICK      = 2'd2;
  localparam logic [1:0] ACT_START     = 2'd3;

  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_UNDERRUN = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOLUME = 1'b1;

  localparam logic [7:0]  SIGN_FLIP      = 8'h80;
  localparam logic [3:0]  DAC_CFG_NIBBLE = 4'h3;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic       sample_is_16bit;
    logic [3:0] volume_shift;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fill_request;
    logic [15:0] underrun_count;
    logic        is_sample;
    logic        wide;
  } cmd_t;

endpackage

`default_nettype wire

### src/dbdp_if.sv
// ----------------------------------------------------------------------------
// dbdp_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbdp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       source_has_more;

  modport source (output valid, action, data_byte, source_has_more, input ready);
  modport sink   (input valid, action, data_byte, source_has_more, output ready);
endinterface

interface dbdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] dac_word;
  logic        fill_request;
  logic [15:0] underrun_count;

  modport source (output valid, kind, dac_word, fill_request, underrun_count, input ready);
  modport sink   (input valid, kind, dac_word, fill_request, underrun_count, output ready);
endinterface

`default_nettype wire

### src/dbdp_ram.sv
// ----------------------------------------------------------------------------
// dbdp_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dbdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/dbdp_fifo.sv
// ----------------------------------------------------------------------------
// dbdp_fifo
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module dbdp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] rdata_o,
  output      logic             full_o,
  output      logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = slot_q[rptr_q];
  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);

endmodule

`default_nettype wire

### src/dbdp_front.sv
// ----------------------------------------------------------------------------
// dbdp_front
// Accepts items, keeps the ping-pong buffer bookkeeping, writes fill bytes
// and queues one command for each result.
// ----------------------------------------------------------------------------
`default_nettype none

module dbdp_front #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  dbdp_in_if.sink                                in_if,
  input  wire dbdp_pkg::cfg_t                    cfg_i,
  input  wire logic                              q_full_i,
  input  wire logic                              rd_pending_i,
  output      logic                              q_push_o,
  output      logic [$clog2(2*BUFFER_BYTES)-1:0] q_addr_o,
  output      dbdp_pkg::cmd_t                    q_cmd_o,
  output      logic                              ram_we_o,
  output      logic [$clog2(2*BUFFER_BYTES)-1:0] ram_waddr_o,
  output      logic [7:0]                        ram_wdata_o
);

  import dbdp_pkg::*;

  localparam int unsigned IW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW = $clog2(2 * BUFFER_BYTES);

  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_FILLING = 2'd2;
  localparam logic [1:0] ST_EOF     = 2'd3;

  logic          play_half_q, play_half_d;
  logic [IW-1:0] play_index_q, play_index_d;
  logic [IW-1:0] play_length_q, play_length_d;
  logic [IW-1:0] fill_index_q, fill_index_d;
  logic [IW-1:0] fill_length_q, fill_length_d;
  logic [1:0]    fill_status_q, fill_status_d;
  logic          playing_q, playing_d;
  logic [15:0]   underruns_q, underruns_d;

  logic          accept;
  logic [IW:0]   need;
  logic          used_up;
  logic          swap_used_up;
  logic [15:0]   bumped;
  logic [AW-1:0] play_base, fill_base;

  assign in_if.ready = !q_full_i && !(in_if.action == ACT_WRITE && rd_pending_i);
  assign accept      = in_if.valid && in_if.ready;

  assign need         = cfg_i.sample_is_16bit ? (IW+1)'(2) : (IW+1)'(1);
  assign used_up      = ({1'b0, play_index_q} + need) > {1'b0, play_length_q};
  assign swap_used_up = cfg_i.sample_is_16bit && (fill_length_q == IW'(1));
  assign bumped       = (in_if.source_has_more && underruns_q != COUNT_MAX) ?
                        underruns_q + 16'd1 : underruns_q;
  assign play_base    = play_half_q ? AW'(BUFFER_BYTES) : '0;
  assign fill_base    = play_half_q ? '0 : AW'(BUFFER_BYTES);

  always_comb begin
    play_half_d   = play_half_q;
    play_index_d  = play_index_q;
    play_length_d = play_length_q;
    fill_index_d  = fill_index_q;
    fill_length_d = fill_length_q;
    fill_status_d = fill_status_q;
    playing_d     = playing_q;
    underruns_d   = underruns_q;
    q_push_o      = 1'b0;
    q_addr_o      = play_base + AW'(play_index_q);
    q_cmd_o       = '{kind: KIND_SAMPLE, fill_request: 1'b0, underrun_count: underruns_q,
                      is_sample: 1'b1, wide: cfg_i.sample_is_16bit};
    ram_we_o      = 1'b0;
    ram_waddr_o   = fill_base + AW'(fill_index_q);
    ram_wdata_o   = in_if.data_byte;

    if (accept) begin
      unique case (in_if.action)
        ACT_WRITE: begin
          if (fill_status_q == ST_FILLING && fill_index_q < IW'(BUFFER_BYTES)) begin
            ram_we_o     = 1'b1;
            fill_index_d = fill_index_q + IW'(1);
          end
        end
        ACT_FILL_DONE: begin
          if (fill_status_q == ST_FILLING) begin
            fill_length_d = fill_index_q;
            fill_status_d = (fill_index_q != '0) ? ST_READY : ST_EOF;
            fill_index_d  = '0;
          end
        end
        ACT_START: begin
          if (fill_status_q == ST_READY) begin
            underruns_d   = '0;
            playing_d     = 1'b1;
            play_index_d  = '0;
            play_length_d = '0;
          end else begin
            playing_d     = 1'b0;
            fill_status_d = ST_FILLING;
            fill_index_d  = '0;
          end
        end
        ACT_TICK: begin
          if (playing_q) begin
            if (!used_up) begin
              q_push_o     = 1'b1;
              play_index_d = play_index_q + need[IW-1:0];
            end else begin
              case (fill_status_q)
                ST_READY: begin
                  play_half_d             = !play_half_q;
                  play_length_d           = fill_length_q;
                  fill_status_d           = ST_FILLING;
                  fill_index_d            = '0;
                  q_push_o                = 1'b1;
                  q_cmd_o.fill_request    = 1'b1;
                  if (swap_used_up) begin
                    play_index_d           = fill_length_q;
                    underruns_d            = bumped;
                    q_cmd_o.kind           = KIND_UNDERRUN;
                    q_cmd_o.is_sample      = 1'b0;
                    q_cmd_o.underrun_count = bumped;
                  end else begin
                    play_index_d = need[IW-1:0];
                    q_addr_o     = fill_base;
                  end
                end
                ST_EOF: begin
                  playing_d         = 1'b0;
                  q_push_o          = 1'b1;
                  q_cmd_o.kind      = KIND_FINISHED;
                  q_cmd_o.is_sample = 1'b0;
                end
                default: begin
                  if (in_if.source_has_more) begin
                    underruns_d            = bumped;
                    q_push_o               = 1'b1;
                    q_cmd_o.kind           = KIND_UNDERRUN;
                    q_cmd_o.is_sample      = 1'b0;
                    q_cmd_o.underrun_count = bumped;
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_half_q   <= 1'b0;
      play_index_q  <= '0;
      play_length_q <= '0;
      fill_index_q  <= '0;
      fill_length_q <= '0;
      fill_status_q <= ST_FILLING;
      playing_q     <= 1'b0;
      underruns_q   <= '0;
    end else begin
      play_half_q   <= play_half_d;
      play_index_q  <= play_index_d;
      play_length_q <= play_length_d;
      fill_index_q  <= fill_index_d;
      fill_length_q <= fill_length_d;
      fill_status_q <= fill_status_d;
      playing_q     <= playing_d;
      underruns_q   <= underruns_d;
    end
  end

endmodule

`default_nettype wire

### src/dbdp_back.sv
// ----------------------------------------------------------------------------
// dbdp_back
// Pops queued commands, reads sample bytes from the buffer RAM, builds the
// DAC frame and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dbdp_back #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dbdp_pkg::cfg_t                    cfg_i,
  input  wire logic                              q_empty_i,
  input  wire logic [$clog2(2*BUFFER_BYTES)-1:0] q_addr_i,
  input  wire dbdp_pkg::cmd_t                    q_cmd_i,
  output      logic                              q_pop_o,
  output      logic                              ram_re_o,
  output      logic [$clog2(2*BUFFER_BYTES)-1:0] ram_raddr_o,
  input  wire logic [7:0]                        ram_rdata_i,
  output      logic                              rd_pending_o,
  dbdp_out_if.source                             out_if
);

  import dbdp_pkg::*;

  localparam int unsigned AW = $clog2(2 * BUFFER_BYTES);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_HI   = 2'd1;
  localparam logic [1:0] BK_FIN  = 2'd2;

  logic [1:0]    st_q, st_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    lo_q, lo_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q;
  logic [15:0]   dac_q;
  logic          req_q;
  logic [15:0]   count_q;

  logic          slot_free;
  logic          take;
  logic          load;
  logic [15:0]   value;
  logic [15:0]   shifted;
  logic [15:0]   dac_word;

  assign slot_free = !out_valid_q || out_if.ready;

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    lo_d        = lo_q;
    take        = 1'b0;
    load        = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;

    unique case (st_q)
      BK_IDLE: begin
        take = !q_empty_i;
      end
      BK_HI: begin
        ram_re_o = 1'b1;
        lo_d     = ram_rdata_i;
        st_d     = BK_FIN;
      end
      BK_FIN: begin
        if (slot_free) begin
          load = 1'b1;
          take = !q_empty_i;
          st_d = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase

    if (take) begin
      cmd_d       = q_cmd_i;
      ram_re_o    = q_cmd_i.is_sample;
      ram_raddr_o = q_addr_i;
      addr_d      = q_addr_i + AW'(1);
      st_d        = (q_cmd_i.is_sample && q_cmd_i.wide) ? BK_HI : BK_FIN;
    end
  end

  assign q_pop_o      = take;
  assign rd_pending_o = (st_q != BK_IDLE) || !q_empty_i;

  assign value    = cmd_q.wide ? {ram_rdata_i ^ SIGN_FLIP, lo_q} : {ram_rdata_i, 8'h00};
  assign shifted  = value >> cfg_i.volume_shift;
  assign dac_word = cmd_q.is_sample ? {DAC_CFG_NIBBLE, shifted[15:4]} : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    addr_q <= addr_d;
    lo_q   <= lo_d;
    if (load) begin
      kind_q  <= cmd_q.kind;
      dac_q   <= dac_word;
      req_q   <= cmd_q.fill_request;
      count_q <= cmd_q.underrun_count;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = kind_q;
  assign out_if.dac_word       = dac_q;
  assign out_if.fill_request   = req_q;
  assign out_if.underrun_count = count_q;

endmodule

`default_nettype wire

### src/double_buffer_dac_player.sv
// ----------------------------------------------------------------------------
// double_buffer_dac_player
// Ping-pong PCM playback engine producing 12-bit serial DAC frames.
//
//   channel  dir  fields                                        handshake
//   in_if    in   action, data_byte, source_has_more            valid/ready
//   out_if   out  kind, dac_word, fill_request, underrun_count  valid/ready
//   cfg      in   cfg_idx_i, cfg_wdata_i                        cfg_we_i
//
// The front takes one transaction per cycle while the command queue is not
// full. The back reads one RAM byte per 8-bit sample and two per 16-bit
// sample through the single RAM read port. A fill byte stalls while sample
// reads are still queued or in flight. No clearing pass after reset: the
// buffer RAM is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_buffer_dac_player_assert.svh"

module double_buffer_dac_player #(
  parameter int unsigned BUFFER_BYTES = dbdp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  dbdp_in_if.sink                              in_if,
  dbdp_out_if.source                           out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [dbdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dbdp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import dbdp_pkg::*;

  localparam int unsigned AW    = $clog2(2 * BUFFER_BYTES);
  localparam int unsigned CMD_W = $bits(cmd_t);

  cfg_t          cfg_q, cfg_d;

  logic          q_push, q_pop, q_full, q_empty;
  logic [AW-1:0] q_addr_in, q_addr_out;
  cmd_t          q_cmd_in, q_cmd_out;
  logic          rd_pending;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDE:   cfg_d.sample_is_16bit = cfg_wdata_i[0];
        CFG_IDX_VOLUME: cfg_d.volume_shift    = cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dbdp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .rd_pending_i (rd_pending),
    .q_push_o     (q_push),
    .q_addr_o     (q_addr_in),
    .q_cmd_o      (q_cmd_in),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  dbdp_fifo #(.WIDTH(AW + CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({q_addr_in, q_cmd_in}),
    .pop_i   (q_pop),
    .rdata_o ({q_addr_out, q_cmd_out}),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dbdp_ram #(.WIDTH(8), .DEPTH(2 * BUFFER_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dbdp_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_addr_i     (q_addr_out),
    .q_cmd_i      (q_cmd_out),
    .q_pop_o      (q_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rd_pending_o (rd_pending),
    .out_if       (out_if)
  );

  `DBDP_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, q_push && q_full,
    "command pushed into a full queue")
  `DBDP_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_empty,
    "command popped from an empty queue")
  `DBDP_ASSERT_NEVER(a_write_during_read, clk_i, rst_ni, ram_we && rd_pending,
    "fill byte written while sample reads are pending")
  `DBDP_ASSERT(a_frame_header, clk_i, rst_ni,
    out_if.valid && out_if.kind == KIND_SAMPLE |-> out_if.dac_word[15:12] == DAC_CFG_NIBBLE,
    "sample frame without DAC config nibble")
  `DBDP_ASSERT(a_status_zero_word, clk_i, rst_ni,
    out_if.valid && out_if.kind != KIND_SAMPLE |-> out_if.dac_word == 16'h0000,
    "status result carries a nonzero DAC word")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double buffer DAC player testbench
// Streams fill, fill-done, tick and start transactions into the player under
// random idling and back-pressure. A behavioral copy of the ping-pong buffers
// predicts each result, and results are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dbdp_pkg::*;

  localparam int unsigned BUF_BYTES      = BUFFER_BYTES_DEFAULT;
  localparam int unsigned IDLE_PCT       = 27;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS   = 760;
  localparam int unsigned CALM_TICKS     = 80;

  typedef enum logic [1:0] {
    FILL_READY   = 2'd1,
    FILL_LOADING = 2'd2,
    FILL_EOF     = 2'd3
  } fill_state_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       more;
  } pcm_txn_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] dac_word;
    logic        fill_request;
    logic [15:0] underrun_count;
  } dac_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dbdp_in_if  in_if();
  dbdp_out_if out_if();

  double_buffer_dac_player #(.BUFFER_BYTES(BUF_BYTES)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pcm_txn_t    txn_queue[$];
  dac_result_t pending_dac[$];
  int unsigned items_made = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;
  logic        in_taken = 1'b0;

  // Predicted player state
  logic [7:0]  pcm_mem [2*BUF_BYTES];
  logic        cur_half;
  int unsigned play_pos, play_len, load_pos, load_len;
  fill_state_e load_state;
  logic        playing;
  logic        wide_mode;
  logic [3:0]  vol_shift;
  logic [15:0] underrun_tally;

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit half_spent();
    int unsigned need;
    need = wide_mode ? 2 : 1;
    return play_pos >= play_len || play_len - play_pos < need;
  endfunction

  function automatic void bump_tally(input logic more);
    if (more && underrun_tally != COUNT_MAX) underrun_tally++;
  endfunction

  function automatic bit predict_dac(input pcm_txn_t t, output dac_result_t r);
    logic [15:0] level;
    int unsigned base;
    r = '0;
    case (t.action)
      ACT_WRITE: begin
        if (load_state == FILL_LOADING && load_pos < BUF_BYTES) begin
          pcm_mem[(cur_half ? 0 : BUF_BYTES) + load_pos] = t.data_byte;
          load_pos++;
        end
        return 1'b0;
      end
      ACT_FILL_DONE: begin
        if (load_state == FILL_LOADING) begin
          load_len   = load_pos;
          load_state = load_pos > 0 ? FILL_READY : FILL_EOF;
          load_pos   = 0;
        end
        return 1'b0;
      end
      ACT_START: begin
        if (load_state == FILL_READY) begin
          underrun_tally = '0;
          playing        = 1'b1;
          play_pos       = 0;
          play_len       = 0;
        end else begin
          playing    = 1'b0;
          load_state = FILL_LOADING;
          load_pos   = 0;
        end
        return 1'b0;
      end
      default: ;
    endcase
    if (!playing) return 1'b0;
    if (half_spent()) begin
      if (load_state == FILL_READY) begin
        cur_half       = ~cur_half;
        play_pos       = 0;
        play_len       = load_len;
        load_state     = FILL_LOADING;
        load_pos       = 0;
        r.fill_request = 1'b1;
        if (half_spent()) begin
          // lone trailing byte in 16-bit mode is dropped
          play_pos = play_len;
          bump_tally(t.more);
          r.kind           = KIND_UNDERRUN;
          r.underrun_count = underrun_tally;
          return 1'b1;
        end
      end else if (load_state == FILL_EOF) begin
        playing          = 1'b0;
        r.kind           = KIND_FINISHED;
        r.underrun_count = underrun_tally;
        return 1'b1;
      end else begin
        if (!t.more) return 1'b0;
        bump_tally(1'b1);
        r.kind           = KIND_UNDERRUN;
        r.underrun_count = underrun_tally;
        return 1'b1;
      end
    end
    base = cur_half ? BUF_BYTES : 0;
    if (wide_mode) begin
      level = {pcm_mem[base + play_pos + 1] ^ SIGN_FLIP, pcm_mem[base + play_pos]};
      play_pos += 2;
    end else begin
      level = {pcm_mem[base + play_pos], 8'h00};
      play_pos += 1;
    end
    level = level >> vol_shift;
    r.kind           = KIND_SAMPLE;
    r.dac_word       = {DAC_CFG_NIBBLE, level[15:4]};
    r.underrun_count = underrun_tally;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Monitor: config shadow, prediction on input, in-order check on output
  always @(posedge clk_i) begin : monitor
    pcm_txn_t    txn;
    dac_result_t got_r, want_r;
    logic        busy;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      busy = 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_WIDE) wide_mode = cfg_wdata_i[0];
        else if (cfg_idx_i == CFG_IDX_VOLUME) vol_shift = cfg_wdata_i;
      end
      if (in_if.valid && in_if.ready) begin
        busy = 1'b1;
        txn = {in_if.action, in_if.data_byte, in_if.source_has_more};
        if (predict_dac(txn, want_r)) pending_dac.push_back(want_r);
      end
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        busy  = 1'b1;
        got_r = {out_if.kind, out_if.dac_word, out_if.fill_request, out_if.underrun_count};
        if (pending_dac.size() == 0) begin
          mismatches++;
          if (mismatches <= 50)
            $display("%0t: unexpected transaction, expected none actual kind %0h word %0h",
                     $time, got_r.kind, got_r.dac_word);
        end else begin
          want_r = pending_dac.pop_front();
          check_field("kind", 16'(want_r.kind), 16'(got_r.kind));
          check_field("dac_word", want_r.dac_word, got_r.dac_word);
          check_field("fill_request", 16'(want_r.fill_request), 16'(got_r.fill_request));
          check_field("underrun_count", want_r.underrun_count, got_r.underrun_count);
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : feeder
    pcm_txn_t t;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (txn_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        t = txn_queue.pop_front();
        in_if.action          <= t.action;
        in_if.data_byte       <= t.data_byte;
        in_if.source_has_more <= t.more;
        in_if.valid           <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : sink
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done    <= hold_reqs;
      stall_left   <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  task automatic push_txn(input logic [1:0] act, input logic [7:0] b, input logic more);
    txn_queue.push_back({act, b, more});
    items_made++;
  endtask

  task automatic push_ticks(input int unsigned n, input int unsigned more_pct);
    repeat (n) push_txn(ACT_TICK, 8'($urandom), $urandom_range(99) < more_pct);
  endtask

  // n fill bytes, a stray tick now and then, then fill done
  task automatic push_fill(input int unsigned n);
    repeat (n) begin
      push_txn(ACT_WRITE, 8'($urandom), 1'($urandom));
      if ($urandom_range(99) < 15) push_ticks(1, 75);
    end
    push_txn(ACT_FILL_DONE, 8'($urandom), 1'($urandom));
  endtask

  function automatic int unsigned pick_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(1, 12);
    if (roll < 95) return $urandom_range(13, 48);
    return 0;
  endfunction

  task automatic push_session(input int unsigned first_len);
    int unsigned len;
    len = first_len != 0 ? first_len : pick_len();
    push_txn(ACT_START, 8'($urandom), 1'($urandom));
    push_fill(len);
    push_txn(ACT_START, 8'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 5)) begin
      push_ticks($urandom_range(0, len + 2), 75);
      len = pick_len();
      push_fill(len);
      if ($urandom_range(99) < 8) push_txn(ACT_START, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(99) < 75) begin
      push_ticks($urandom_range(len, len + 2), 75);
      push_txn(ACT_FILL_DONE, 8'($urandom), 1'($urandom));
      push_ticks(len + 3, 75);
    end
  endtask

  task automatic push_noise(input int unsigned n);
    repeat (n) push_txn(2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // wait for all traffic and expected results, then let the pipeline empty
  task automatic settle();
    while (txn_queue.size() != 0 || in_if.valid || pending_dac.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned random_goal;
    int unsigned session;
    logic        wide;
    logic [3:0]  vol;

    in_if.valid           = 1'b0;
    in_if.action          = ACT_WRITE;
    in_if.data_byte       = 8'h00;
    in_if.source_has_more = 1'b0;
    out_if.ready          = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_IDX_WIDE;
    cfg_wdata_i           = '0;
    cur_half              = 1'b0;
    play_pos              = 0;
    play_len              = 0;
    load_pos              = 0;
    load_len              = 0;
    load_state            = FILL_LOADING;
    playing               = 1'b0;
    wide_mode             = 1'b0;
    vol_shift             = '0;
    underrun_tally        = '0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // 8-bit mode, full volume
    push_txn(ACT_TICK, 8'h00, 1'b1);        // stopped
    push_txn(ACT_START, 8'h00, 1'b0);       // nothing ready
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);   // empty fill: end of file
    push_txn(ACT_WRITE, 8'hAA, 1'b0);       // not loading
    push_txn(ACT_FILL_DONE, 8'h00, 1'b1);   // not loading
    push_txn(ACT_START, 8'hFF, 1'b1);
    push_txn(ACT_WRITE, 8'h00, 1'b0);
    push_txn(ACT_WRITE, 8'hFF, 1'b1);
    push_txn(ACT_WRITE, 8'h80, 1'b0);
    push_txn(ACT_WRITE, 8'h7F, 1'b1);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_WRITE, 8'h55, 1'b1);       // half already ready
    push_txn(ACT_START, 8'h00, 1'b0);
    push_ticks(4, 50);
    push_txn(ACT_TICK, 8'h00, 1'b1);        // underrun
    push_txn(ACT_TICK, 8'hFF, 1'b0);        // source drained: silent
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_TICK, 8'h00, 1'b0);        // finished
    push_txn(ACT_TICK, 8'h00, 1'b1);
    settle();

    // 16-bit mode: sign flip, odd trailing byte, restart while playing
    write_reg(CFG_IDX_WIDE, 4'd1);
    write_reg(CFG_IDX_VOLUME, 4'd0);
    push_txn(ACT_START, 8'h00, 1'b0);
    push_txn(ACT_WRITE, 8'h00, 1'b0);
    push_txn(ACT_WRITE, 8'h80, 1'b0);
    push_txn(ACT_WRITE, 8'hFF, 1'b0);
    push_txn(ACT_WRITE, 8'h7F, 1'b0);
    push_txn(ACT_WRITE, 8'h34, 1'b0);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_START, 8'h00, 1'b0);
    push_ticks(2, 0);
    push_txn(ACT_TICK, 8'h00, 1'b1);        // one byte left: spent
    push_txn(ACT_START, 8'h00, 1'b0);       // loading: stops
    push_txn(ACT_WRITE, 8'h12, 1'b0);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_START, 8'h00, 1'b0);
    push_txn(ACT_TICK, 8'h00, 1'b0);        // single-byte half dropped
    push_txn(ACT_TICK, 8'h00, 1'b1);
    push_txn(ACT_WRITE, 8'h9A, 1'b0);
    push_txn(ACT_WRITE, 8'hBC, 1'b0);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_START, 8'h00, 1'b1);       // restart while playing
    push_txn(ACT_TICK, 8'h00, 1'b0);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_TICK, 8'h00, 1'b0);
    settle();

    // long run of underruns, no idling on either side
    write_reg(CFG_IDX_WIDE, 4'd0);
    write_reg(CFG_IDX_VOLUME, 4'd7);
    calm = 1'b1;
    push_txn(ACT_START, 8'h00, 1'b0);
    push_fill(2);
    push_txn(ACT_START, 8'h00, 1'b0);
    push_ticks(2, 0);
    push_ticks(CALM_TICKS, 100);
    push_txn(ACT_FILL_DONE, 8'h00, 1'b0);
    push_txn(ACT_TICK, 8'h00, 1'b0);
    settle();
    calm = 1'b0;

    random_goal = items_made + RANDOM_ITEMS;
    session     = 0;
    while (items_made < random_goal) begin
      settle();
      case ($urandom_range(0, 5))
        0:       begin wide = 1'b0; vol = 4'd0;  end
        1:       begin wide = 1'b1; vol = 4'd15; end
        2:       begin wide = 1'b0; vol = 4'd15; end
        3:       begin wide = 1'b1; vol = 4'd0;  end
        default: begin wide = 1'($urandom); vol = 4'($urandom_range(0, 8)); end
      endcase
      write_reg(CFG_IDX_WIDE, {3'b000, wide});
      write_reg(CFG_IDX_VOLUME, vol);
      if (session == 1) begin
        // long output stall while ticks keep arriving
        hold_reqs++;
        push_txn(ACT_START, 8'($urandom), 1'b1);
        push_fill(30);
        push_txn(ACT_START, 8'($urandom), 1'b1);
        push_ticks(40, 100);
      end else if (session == 3) begin
        // full half plus ignored overflow bytes
        push_txn(ACT_START, 8'($urandom), 1'($urandom));
        push_fill(BUF_BYTES + 3);
        push_txn(ACT_START, 8'($urandom), 1'($urandom));
        push_ticks(24, 75);
      end else if ($urandom_range(99) < 15) begin
        push_noise(30);
      end else begin
        push_session(0);
      end
      session++;
    end
    settle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
